// ----- rtl/core/dsm_pkg.sv -----
package dsm_pkg;

  // Default number of pattern bytes the cell row can hold.
  localparam int PATTERN_MAX_DEFAULT = 16;

  // Pattern bytes that the two configuration words can supply.
  localparam int STORED_BYTES = 16;

  localparam int CHAR_W      = 8;
  localparam int LEN_W       = 5;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;

  // Special pattern bytes.
  localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_STAR = 8'h2A;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

  // Per-position view of the pattern, handed to each cell.
  typedef struct packed {
    logic [CHAR_W-1:0] pat_byte;  // byte at this position
    logic              star;      // position is a starred token
    logic              in_range;  // position holds a byte (j < length)
    logic              keep;      // position exists (j <= length)
  } cell_cfg_t;

  // Per-cycle step control, shared by every cell.
  typedef struct packed {
    logic              load;      // a transaction is accepted this cycle
    logic              last;      // it closes the subject
    logic [CHAR_W-1:0] ch;        // subject byte
  } step_t;

endpackage

// ----- rtl/core/dsm_channels.sv -----
// Subject byte channel.
interface dsm_text_if;
  logic                          valid;
  logic                          ready;
  logic [dsm_pkg::CHAR_W-1:0]    text_char;
  logic                          is_last;

  modport source (output valid, output text_char, output is_last, input ready);
  modport sink   (input valid, input text_char, input is_last, output ready);
endinterface

// Match result channel.
interface dsm_result_if;
  logic valid;
  logic ready;
  logic prefix_match;
  logic subject_done;

  modport source (output valid, output prefix_match, output subject_done, input ready);
  modport sink   (input valid, input prefix_match, input subject_done, output ready);
endinterface

// ----- rtl/core/dot_star_pattern_matcher.sv -----
// Whole-string matcher for patterns of literal bytes, '.' (any byte) and
// "x*" (zero or more of x), held in configuration registers.
// Configuration: cfg_write_enable, cfg_index and cfg_data write the low
// pattern word, the high pattern word or the pattern length. Writes must
// be made while no transaction is in flight; the block does not enforce it.
// Input channel "text": one subject byte per transaction, is_last marks
// the final byte of a subject. Output channel "result": one transaction
// per input byte with prefix_match (subject so far matches the whole
// pattern) and subject_done (copy of is_last).
// A result is registered and is valid in the cycle after acceptance.
// Throughput is one byte per cycle while results are taken: each byte
// steps a row of PATTERN_MAX+1 position cells combinationally, with the
// star-skip closure rippling along it. The output register frees the
// input whenever the result is taken in the same cycle; when the receiver
// stalls, the result holds and text.ready drops until it is taken.
// Reset clears the pattern to empty and puts the live set at the start
// position; after each final byte the set returns to the start.
module dot_star_pattern_matcher #(
  parameter int PATTERN_MAX = dsm_pkg::PATTERN_MAX_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_enable,
  input  logic [dsm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [dsm_pkg::CFG_DATA_W-1:0]      cfg_data,
  dsm_text_if.sink                            text,
  dsm_result_if.source                        result
);

  localparam int POS_W   = $clog2(PATTERN_MAX + 1);
  localparam int CELLS   = PATTERN_MAX + 1;

  logic [dsm_pkg::CFG_DATA_W-1:0] pattern_low;
  logic [dsm_pkg::CFG_DATA_W-1:0] pattern_high;
  logic [dsm_pkg::LEN_W-1:0]      pattern_length;

  logic [2*dsm_pkg::CFG_DATA_W-1:0] pattern_word;
  logic [dsm_pkg::CHAR_W-1:0]       pbyte [CELLS+1];
  logic [POS_W-1:0]                 n;
  logic [POS_W:0]                   n_ext;

  dsm_pkg::cell_cfg_t cell_cfg [CELLS];
  dsm_pkg::step_t     step;

  logic [CELLS-1:0] carry;
  logic [CELLS-1:0] ncarry;
  logic [CELLS-1:0] adv;
  logic [CELLS-1:0] reach;

  logic accept;
  logic out_valid;
  logic out_match;
  logic out_done;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        dsm_pkg::REG_PATTERN_LOW:    pattern_low    <= cfg_data;
        dsm_pkg::REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        dsm_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_data[dsm_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective length, clamped to PATTERN_MAX, the last position of the cell row.
  always_comb begin
    if (pattern_length > dsm_pkg::LEN_W'(PATTERN_MAX)) begin
      n = POS_W'(PATTERN_MAX);
    end else begin
      n = POS_W'(pattern_length);
    end
    n_ext = {1'b0, n};
  end

  assign pattern_word = {pattern_high, pattern_low};

  // Pattern bytes by position; positions past the stored words read as zero.
  for (genvar k = 0; k <= CELLS; k++) begin : g_byte
    if (k < dsm_pkg::STORED_BYTES) begin : g_stored
      assign pbyte[k] = pattern_word[dsm_pkg::CHAR_W*k +: dsm_pkg::CHAR_W];
    end else begin : g_zero
      assign pbyte[k] = '0;
    end
  end

  // Handshake: the output register takes a new result when empty or drained.
  assign text.ready = ~out_valid | result.ready;
  assign accept     = text.valid & text.ready;

  assign step.load = accept;
  assign step.last = text.is_last;
  assign step.ch   = text.text_char;

  // Row of position cells with their neighbor links.
  for (genvar j = 0; j < CELLS; j++) begin : g_cell
    logic carry_in;
    logic ncarry_in;
    logic adv_in;

    assign cell_cfg[j].pat_byte = pbyte[j];
    assign cell_cfg[j].star     = ((POS_W+1)'(j + 1) < n_ext) &&
                                  (pbyte[j+1] == dsm_pkg::CHAR_STAR);
    assign cell_cfg[j].in_range = (POS_W+1)'(j) < n_ext;
    assign cell_cfg[j].keep     = (POS_W+1)'(j) <= n_ext;

    if (j >= 2) begin : g_skip
      assign carry_in  = carry[j-2];
      assign ncarry_in = ncarry[j-2];
    end else begin : g_noskip
      assign carry_in  = 1'b0;
      assign ncarry_in = 1'b0;
    end

    if (j >= 1) begin : g_step
      assign adv_in = adv[j-1];
    end else begin : g_nostep
      assign adv_in = 1'b0;
    end

    dsm_cell #(
      .START (j == 0)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cfg        (cell_cfg[j]),
      .step       (step),
      .carry_in   (carry_in),
      .ncarry_in  (ncarry_in),
      .adv_in     (adv_in),
      .carry_out  (carry[j]),
      .ncarry_out (ncarry[j]),
      .adv_out    (adv[j]),
      .reach      (reach[j])
    );
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (text.ready) begin
      out_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_match <= reach[n];
      out_done  <= text.is_last;
    end
  end

  assign result.valid        = out_valid;
  assign result.prefix_match = out_match;
  assign result.subject_done = out_done;

endmodule

// ----- rtl/core/dsm_cell.sv -----
// One pattern position. The cell holds its live bit, forwards the
// star-skip closure two positions ahead and the byte advance one ahead.
module dsm_cell #(
  parameter bit START = 1'b0
) (
  input  logic                clk,
  input  logic                rst,
  input  dsm_pkg::cell_cfg_t  cfg,
  input  dsm_pkg::step_t      step,
  input  logic                carry_in,
  input  logic                ncarry_in,
  input  logic                adv_in,
  output logic                carry_out,
  output logic                ncarry_out,
  output logic                adv_out,
  output logic                reach
);

  logic live;
  logic cur;
  logic hit;
  logic match;
  logic nxt;

  // Closure of the stored set, then the byte step.
  always_comb begin
    cur       = (live & cfg.keep) | carry_in;
    hit       = (cfg.pat_byte == step.ch) || (cfg.pat_byte == dsm_pkg::CHAR_DOT);
    match     = cur & cfg.in_range & hit;
    carry_out = cur & cfg.star;
    nxt       = (match & cfg.star) | adv_in;
    adv_out   = match & ~cfg.star;
  end

  // Closure of the stepped set, used for the match result.
  always_comb begin
    reach      = nxt | ncarry_in;
    ncarry_out = reach & cfg.star;
  end

  // Live bit; a finished subject returns the row to the start position.
  always_ff @(posedge clk) begin
    if (rst) begin
      live <= START;
    end else if (step.load) begin
      live <= step.last ? START : nxt;
    end
  end

endmodule

// ----- sim/dot_star_pattern_matcher_tb.sv -----
// Tracks the pattern registers and the live position set, predicts one verdict per
// subject byte, and compares each result transaction with the oldest prediction.
class prefix_match_checker;
  localparam int PMAX = dsm_pkg::PATTERN_MAX_DEFAULT;

  typedef logic [PMAX:0] pos_set_t;
  typedef struct packed {
    logic prefix_match;
    logic subject_done;
  } verdict_t;

  logic [63:0] pattern_low;
  logic [63:0] pattern_high;
  logic [4:0]  pattern_length;
  pos_set_t    live_set;
  verdict_t    expected_verdicts[$];
  int          mismatches;

  function new();
    pattern_low    = '0;
    pattern_high   = '0;
    pattern_length = '0;
    live_set       = pos_set_t'(1);
    mismatches     = 0;
  endfunction

  function void write_reg(logic [dsm_pkg::CFG_INDEX_W-1:0] idx,
                          logic [dsm_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      dsm_pkg::REG_PATTERN_LOW:    pattern_low = data;
      dsm_pkg::REG_PATTERN_HIGH:   pattern_high = data;
      dsm_pkg::REG_PATTERN_LENGTH: pattern_length = data[4:0];
      default: ;
    endcase
  endfunction

  function logic [7:0] pattern_byte(int k);
    if (k < 8) return pattern_low[8*k +: 8];
    if (k < 16) return pattern_high[8*(k-8) +: 8];
    return 8'h00;
  endfunction

  // A position is a starred token when the byte after it, still inside the pattern, is a star.
  function bit starred(int j, int n);
    return (j + 1 < n) && (pattern_byte(j + 1) == dsm_pkg::CHAR_STAR);
  endfunction

  // Add every position reached by skipping starred tokens; the ripple runs low to high.
  function pos_set_t skip_stars(pos_set_t s, int n);
    for (int j = 0; j <= n; j++) begin
      if (s[j] && starred(j, n)) s[j+2] = 1'b1;
    end
    return s;
  endfunction

  // Step the live set with one accepted subject byte and queue the verdict.
  function void note_byte(logic [7:0] ch, logic last);
    int         n;
    int         j;
    pos_set_t   cur;
    pos_set_t   nxt;
    pos_set_t   reach;
    logic [7:0] pb;
    verdict_t   v;
    n = (pattern_length > PMAX) ? PMAX : int'(pattern_length);
    cur = live_set;
    // Positions beyond the current length are dropped.
    for (j = n + 1; j <= PMAX; j++) cur[j] = 1'b0;
    cur = skip_stars(cur, n);
    nxt = '0;
    for (j = 0; j < n; j++) begin
      pb = pattern_byte(j);
      if (cur[j] && (pb == ch || pb == dsm_pkg::CHAR_DOT)) begin
        if (starred(j, n)) nxt[j] = 1'b1;
        else nxt[j+1] = 1'b1;
      end
    end
    reach = skip_stars(nxt, n);
    v.prefix_match = reach[n];
    v.subject_done = last;
    expected_verdicts.push_back(v);
    live_set = last ? pos_set_t'(1) : nxt;
  endfunction

  function void report(string field, logic expv, logic actv);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0b, got %0b", field, expv, actv);
  endfunction

  function void check_result(logic pm, logic sd);
    verdict_t v;
    if (expected_verdicts.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result transaction with none expected: prefix_match %0b, subject_done %0b",
                 pm, sd);
      return;
    end
    v = expected_verdicts.pop_front();
    if (pm !== v.prefix_match) report("prefix_match", v.prefix_match, pm);
    if (sd !== v.subject_done) report("subject_done", v.subject_done, sd);
  endfunction

  function int pending();
    return expected_verdicts.size();
  endfunction
endclass

module dot_star_pattern_matcher_tb;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int STALL_STRETCH = 300;
  localparam int MODE_ITEMS    = 400;
  localparam int PMAX          = dsm_pkg::PATTERN_MAX_DEFAULT;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_write_enable;
  logic [dsm_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [dsm_pkg::CFG_DATA_W-1:0]  cfg_data;

  dsm_text_if   text_ch ();
  dsm_result_if result_ch ();

  dot_star_pattern_matcher uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .text             (text_ch),
    .result           (result_ch)
  );

  prefix_match_checker matcher_model = new();

  int         send_idle_pct;
  int         recv_idle_pct;
  int         stall_left;
  int         cycle_count;
  int         bytes_sent;
  logic [7:0] pattern_bytes[16];
  int         pattern_span;
  logic [7:0] subject_q[$];

  always #2 clk = ~clk;

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: a long hold-off when requested, otherwise random stalls.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= !(recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Check results before noting new input, so the oldest expectation is consumed first.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_ch.valid && result_ch.ready)
        matcher_model.check_result(result_ch.prefix_match, result_ch.subject_done);
      if (text_ch.valid && text_ch.ready)
        matcher_model.note_byte(text_ch.text_char, text_ch.is_last);
    end
  end

  // Random subject bytes favor the small alphabet of the pattern literals so that they hit them.
  function logic [7:0] random_text_byte();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return 8'("a" + $urandom_range(0, 1));
  endfunction

  // Build a subject that matches the current pattern, with random star repeats.
  function void build_matching();
    int         i;
    int         k;
    int         reps;
    logic [7:0] tok;
    subject_q.delete();
    i = 0;
    while (i < pattern_span) begin
      tok = pattern_bytes[i];
      if (i + 1 < pattern_span && pattern_bytes[i+1] == dsm_pkg::CHAR_STAR) begin
        reps = $urandom_range(0, 3);
        for (k = 0; k < reps; k++)
          subject_q.push_back(tok == dsm_pkg::CHAR_DOT ? random_text_byte() : tok);
        i += 2;
      end else begin
        subject_q.push_back(tok == dsm_pkg::CHAR_DOT ? random_text_byte() : tok);
        i++;
      end
    end
    if (subject_q.size() == 0) subject_q.push_back(random_text_byte());
  endfunction

  // Break a well-formed subject: replace, append or drop one byte.
  function void mutate_subject();
    case ($urandom_range(0, 2))
      0: subject_q[$urandom_range(0, subject_q.size() - 1)] = 8'($urandom_range(0, 255));
      1: subject_q.push_back(random_text_byte());
      default: begin
        if (subject_q.size() > 1) void'(subject_q.pop_back());
        else subject_q.push_back(random_text_byte());
      end
    endcase
  endfunction

  function void build_noise(int max_len);
    subject_q.delete();
    repeat ($urandom_range(1, max_len)) subject_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  function void load_text(string s);
    subject_q.delete();
    for (int k = 0; k < s.len(); k++) subject_q.push_back(s[k]);
  endfunction

  // Bytes past the string are random, so stored bytes outside the length vary too.
  function void load_pattern(string s);
    for (int k = 0; k < 16; k++)
      pattern_bytes[k] = (k < s.len()) ? s[k] : 8'($urandom_range(0, 255));
  endfunction

  // Offer one transaction on the text channel, with random idle cycles before it.
  task automatic send_byte(input logic [7:0] ch, input logic last);
    @(negedge clk);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      text_ch.valid <= 1'b0;
      @(negedge clk);
    end
    text_ch.valid     <= 1'b1;
    text_ch.text_char <= ch;
    text_ch.is_last   <= last;
    do @(posedge clk); while (!text_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_subject(input logic close);
    for (int i = 0; i < subject_q.size(); i++)
      send_byte(subject_q[i], close && (i == subject_q.size() - 1));
  endtask

  // Stop offering input and wait until every expected result has been taken.
  task automatic settle();
    @(negedge clk);
    text_ch.valid <= 1'b0;
    while (matcher_model.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [dsm_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [dsm_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index        <= idx;
    cfg_data         <= data;
    matcher_model.write_reg(idx, data);
  endtask

  // Load pattern_bytes into the block with the given length code, once it is idle.
  task automatic apply_pattern(input int code);
    logic [63:0] lo;
    logic [63:0] hi;
    settle();
    for (int k = 0; k < 8; k++) begin
      lo[8*k +: 8] = pattern_bytes[k];
      hi[8*k +: 8] = pattern_bytes[k+8];
    end
    write_reg(dsm_pkg::REG_PATTERN_LOW, lo);
    write_reg(dsm_pkg::REG_PATTERN_HIGH, hi);
    write_reg(dsm_pkg::REG_PATTERN_LENGTH, 64'(code));
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    pattern_span = (code > PMAX) ? PMAX : code;
  endtask

  // Random pattern, now and then an all-ones or all-zeros word pair or an oversized length.
  task automatic random_pattern();
    int r;
    int kind;
    int code;
    for (int k = 0; k < 16; k++) begin
      r = $urandom_range(0, 99);
      if (r < 40) pattern_bytes[k] = 8'("a" + $urandom_range(0, 1));
      else if (r < 60) pattern_bytes[k] = dsm_pkg::CHAR_DOT;
      else if (r < 85) pattern_bytes[k] = dsm_pkg::CHAR_STAR;
      else pattern_bytes[k] = 8'($urandom_range(0, 255));
    end
    kind = $urandom_range(0, 99);
    code = $urandom_range(0, 16);
    if (kind < 5) begin
      foreach (pattern_bytes[k]) pattern_bytes[k] = 8'hFF;
      code = 16;
    end else if (kind < 10) begin
      foreach (pattern_bytes[k]) pattern_bytes[k] = 8'h00;
      code = 16;
    end else if (kind < 15) begin
      code = $urandom_range(17, 31);
    end
    apply_pattern(code);
  endtask

  // One idling setting: phases of one pattern each, with a long receiver hold-off midway.
  task automatic run_mode(input int s_pct, input int r_pct);
    int start;
    int phase_start;
    int phase_len;
    int r;
    bit pressed;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    start   = bytes_sent;
    pressed = 1'b0;
    while (bytes_sent - start < MODE_ITEMS) begin
      random_pattern();
      phase_len   = $urandom_range(20, 60);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < phase_len) begin
        if (!pressed && bytes_sent - start >= MODE_ITEMS / 2) begin
          stall_left = STALL_STRETCH;
          pressed    = 1'b1;
        end
        r = $urandom_range(0, 99);
        if (r < 70) begin
          build_matching();
        end else if (r < 88) begin
          build_matching();
          mutate_subject();
        end else begin
          build_noise(12);
        end
        send_subject(1'b1);
      end
      // Sometimes leave a subject open so the next pattern change lands mid subject.
      if ($urandom_range(0, 3) == 0) begin
        build_noise(4);
        send_subject(1'b0);
      end
    end
  endtask

  initial begin
    rst                 = 1'b1;
    cfg_write_enable    = 1'b0;
    cfg_index           = dsm_pkg::REG_PATTERN_LOW;
    cfg_data            = '0;
    text_ch.valid       = 1'b0;
    text_ch.text_char   = '0;
    text_ch.is_last     = 1'b0;
    result_ch.ready     = 1'b0;
    send_idle_pct       = 0;
    recv_idle_pct       = 0;
    stall_left          = 0;
    bytes_sent          = 0;
    pattern_span        = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty pattern after reset never matches; extreme byte values.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);

    // Stray star at the front, a dot and a trailing starred token.
    load_pattern("*x.b*");
    apply_pattern(5);
    load_text("*xZ");
    send_subject(1'b1);
    load_text("*xZbb");
    send_subject(1'b1);

    // A star after a starred token is a literal star.
    load_pattern("a**");
    apply_pattern(3);
    load_text("aa*");
    send_subject(1'b1);

    // Shorten the pattern mid subject: live positions past the new end are dropped.
    load_pattern("abc");
    apply_pattern(3);
    load_text("ab");
    send_subject(1'b0);
    apply_pattern(1);
    send_byte("x", 1'b1);
    send_byte("a", 1'b1);

    // Length above the cell row is clamped; an all dot-star pattern matches anything.
    load_pattern(".*.*.*.*.*.*.*.*");
    apply_pattern(31);
    send_byte("q", 1'b0);
    send_byte(8'h80, 1'b1);

    run_mode(36, 49);
    run_mode(49, 36);
    run_mode(0, 0);

    settle();
    repeat (8) @(posedge clk);
    if (matcher_model.mismatches == 0 && matcher_model.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
